// File: hw/rtl/wwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind window averager package
// Shared constants and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package wwa_pkg;

    // Default window length in samples.
    localparam int WINDOW_LEN_DEF = 120;

    // Field widths.
    localparam int ANGLE_W = 12;
    localparam int SPEED_W = 11;

    // Angle constants in tenths of a degree.
    localparam logic [ANGLE_W-1:0] OFFSET_RESET = 12'd750;
    localparam logic [ANGLE_W-1:0] ANGLE_FULL   = 12'd3600;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 12'd1800;
    localparam logic [ANGLE_W-1:0] SOUTH_LO     = 12'd900;
    localparam logic [ANGLE_W-1:0] SOUTH_HI     = 12'd2700;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;     // capture the input word
        logic fetch_old;   // wrap the angle and read the oldest ring entry
        logic update;      // update the totals and overwrite the oldest entry
        logic clr_write;   // write zero at the sweep address
        logic scan_read;   // read the speed ring at the sweep address
        logic sweep_step;  // advance the sweep address
        logic scan_start;  // clear the gust and start both dividers
        logic load_out;    // load the output word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_first; // sweep address is at entry zero
        logic sweep_last;  // sweep address is at the last entry
        logic div_done;    // both dividers are idle
        logic out_busy;    // output word is held and not taken this cycle
    } t_sts;

endpackage

// File: hw/rtl/wwa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divisor divider
// Division by a fixed divisor through multiplication by a scaled reciprocal,
// with the numerator and the quotient both registered.
// ----------------------------------------------------------------------------
module wwa_div #(
    parameter int NUM_W   = 19,
    parameter int DIVISOR = 120,
    parameter int Q_W     = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quo
);

    // With a shift of NUM_W plus the divisor's bit count, the rounded-up
    // reciprocal gives the exact truncated quotient for every numerator.
    localparam int SH  = NUM_W + $clog2(DIVISOR);
    localparam int M_W = NUM_W + 1;
    localparam int P_W = NUM_W + M_W;
    localparam logic [M_W-1:0] RECIP =
        M_W'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [NUM_W-1:0] r_num;
    logic             r_busy;
    logic [Q_W-1:0]   r_quo;
    logic [P_W-1:0]   prod;

    // Busy for the one cycle in which the product is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // Numerator capture.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
    end

    // Reciprocal product; the quotient is its upper part.
    assign prod = P_W'(r_num) * P_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_quo <= Q_W'(prod >> SH);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: hw/rtl/wwa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind window averager datapath
// Offset register, sample rings, running totals, gust scan, dividers and
// the output word register.
// ----------------------------------------------------------------------------
module wwa_datapath #(
    parameter int WINDOW_LEN = wwa_pkg::WINDOW_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wwa_pkg::t_cmd               i_cmd,
    output wwa_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [wwa_pkg::ANGLE_W-1:0] i_cfg_wdata,
    input  logic [wwa_pkg::ANGLE_W-1:0] i_raw_angle,
    input  logic [wwa_pkg::SPEED_W-1:0] i_wind_speed,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [wwa_pkg::SPEED_W-1:0] o_mean_speed,
    output logic [wwa_pkg::SPEED_W-1:0] o_gust_speed,
    output logic [wwa_pkg::ANGLE_W-1:0] o_true_angle,
    output logic [wwa_pkg::ANGLE_W-1:0] o_mean_angle
);

    localparam int AW    = wwa_pkg::ANGLE_W;
    localparam int SW    = wwa_pkg::SPEED_W;
    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int ST_W  = $clog2(WINDOW_LEN * 2047 + 1);
    localparam int AT_W  = $clog2(WINDOW_LEN * 3599 + 1);
    localparam int SC_W  = $clog2(WINDOW_LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(WINDOW_LEN - 1);
    localparam logic [AT_W-1:0]  BIASED_INIT = AT_W'(WINDOW_LEN * 1800);
    localparam logic [SC_W-1:0]  HALF_LEN    = SC_W'(WINDOW_LEN / 2);
    localparam logic [AW:0]      FULL_X1     = {1'b0, wwa_pkg::ANGLE_FULL};
    localparam logic [AW:0]      FULL_X2     = {wwa_pkg::ANGLE_FULL, 1'b0};

    // Angle shifted by half a turn, so that angles near north sum smoothly.
    function automatic logic [AW-1:0] biased_of(input logic [AW-1:0] a);
        logic [AW-1:0] res;
        if (a < wwa_pkg::ANGLE_HALF) begin
            res = a + wwa_pkg::ANGLE_HALF;
        end else begin
            res = a - wwa_pkg::ANGLE_HALF;
        end
        return res;
    endfunction

    // An angle lies south when it is above 900 and at most 2700.
    function automatic logic is_south(input logic [AW-1:0] a);
        return (a > wwa_pkg::SOUTH_LO) && (a <= wwa_pkg::SOUTH_HI);
    endfunction

    logic [AW-1:0]    r_offset;
    logic [AW:0]      r_sum;
    logic [SW-1:0]    r_spd;
    logic [AW-1:0]    r_ang, n_ang;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] r_sweep;
    logic [ST_W-1:0]  r_speed_tot;
    logic [AT_W-1:0]  r_angle_tot;
    logic [AT_W-1:0]  r_biased_tot;
    logic [SC_W-1:0]  r_south;
    logic [SC_W-1:0]  n_south;
    logic             r_plain;
    logic             r_scan_v;
    logic [SW-1:0]    r_gust;
    logic             r_out_valid;

    // Sample rings with one shared address per port.
    logic [SW-1:0]    speed_mem [WINDOW_LEN];
    logic [AW-1:0]    angle_mem [WINDOW_LEN];
    logic [SW-1:0]    r_rd_s;
    logic [AW-1:0]    r_rd_a;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             mem_we, mem_re;
    logic [SW-1:0]    wr_s;
    logic [AW-1:0]    wr_a;

    logic             spd_busy, ang_busy;
    logic [SW-1:0]    spd_quo;
    logic [AW-1:0]    ang_quo;
    logic [AT_W-1:0]  ang_num;
    logic [AW-1:0]    mean_ang;

    // Mounting offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= wwa_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    // Input capture: the offset sum is wrapped in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_sum <= {1'b0, i_raw_angle} + {1'b0, r_offset};
            r_spd <= i_wind_speed;
        end
        if (i_cmd.fetch_old) begin
            r_ang <= n_ang;
        end
    end

    // The sum is below twice the full turn plus one turn, so two compares do.
    always_comb begin
        if (r_sum >= FULL_X2) begin
            n_ang = AW'(r_sum - FULL_X2);
        end else if (r_sum >= FULL_X1) begin
            n_ang = AW'(r_sum - FULL_X1);
        end else begin
            n_ang = r_sum[AW-1:0];
        end
    end

    // Ring port selection.
    always_comb begin
        mem_re  = i_cmd.fetch_old | i_cmd.scan_read;
        rd_addr = i_cmd.fetch_old ? r_slot : r_sweep;
        mem_we  = i_cmd.clr_write | i_cmd.update;
        wr_addr = i_cmd.clr_write ? r_sweep : r_slot;
        wr_s    = i_cmd.clr_write ? '0 : r_spd;
        wr_a    = i_cmd.clr_write ? '0 : r_ang;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            speed_mem[wr_addr] <= wr_s;
            angle_mem[wr_addr] <= wr_a;
        end
        if (mem_re) begin
            r_rd_s <= speed_mem[rd_addr];
            r_rd_a <= angle_mem[rd_addr];
        end
    end

    // South count after removing the oldest entry and adding the new one.
    always_comb begin
        n_south = r_south;
        if (is_south(r_rd_a)) begin
            n_south = n_south - 1'b1;
        end
        if (is_south(r_ang)) begin
            n_south = n_south + 1'b1;
        end
    end

    // Running totals, write slot and sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot       <= '0;
            r_sweep      <= '0;
            r_speed_tot  <= '0;
            r_angle_tot  <= '0;
            r_biased_tot <= BIASED_INIT;
            r_south      <= '0;
        end else begin
            if (i_cmd.update) begin
                r_speed_tot  <= r_speed_tot - ST_W'(r_rd_s) + ST_W'(r_spd);
                r_angle_tot  <= r_angle_tot - AT_W'(r_rd_a) + AT_W'(r_ang);
                r_biased_tot <= r_biased_tot - AT_W'(biased_of(r_rd_a))
                                + AT_W'(biased_of(r_ang));
                r_south      <= n_south;
                r_slot       <= (r_slot == LAST_IDX) ? '0 : r_slot + 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= (r_sweep == LAST_IDX) ? '0 : r_sweep + 1'b1;
            end
        end
    end

    // Gust scan: the speed ring read data is registered, so the scan valid flag is registered with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_v <= 1'b0;
        end else begin
            r_scan_v <= i_cmd.scan_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_gust  <= '0;
            r_plain <= r_south > HALF_LEN;
        end else if (r_scan_v && (r_rd_s > r_gust)) begin
            r_gust <= r_rd_s;
        end
    end

    // Dividers for the two means.
    assign ang_num = (r_south > HALF_LEN) ? r_angle_tot : r_biased_tot;

    wwa_div #(
        .NUM_W   (ST_W),
        .DIVISOR (WINDOW_LEN),
        .Q_W     (SW)
    ) u_div_spd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.scan_start),
        .i_num   (r_speed_tot),
        .o_busy  (spd_busy),
        .o_quo   (spd_quo)
    );

    wwa_div #(
        .NUM_W   (AT_W),
        .DIVISOR (WINDOW_LEN),
        .Q_W     (AW)
    ) u_div_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.scan_start),
        .i_num   (ang_num),
        .o_busy  (ang_busy),
        .o_quo   (ang_quo)
    );

    // Undo the half-turn bias; a result of zero or below wraps up to 3600.
    always_comb begin
        if (r_plain) begin
            mean_ang = ang_quo;
        end else if (ang_quo > wwa_pkg::ANGLE_HALF) begin
            mean_ang = ang_quo - wwa_pkg::ANGLE_HALF;
        end else begin
            mean_ang = ang_quo + wwa_pkg::ANGLE_HALF;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mean_speed <= spd_quo;
            o_gust_speed <= r_gust;
            o_true_angle <= r_ang;
            o_mean_angle <= mean_ang;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status back to the controller.
    always_comb begin
        o_sts.sweep_first = (r_sweep == '0);
        o_sts.sweep_last  = (r_sweep == LAST_IDX);
        o_sts.div_done    = ~spd_busy & ~ang_busy;
        o_sts.out_busy    = r_out_valid & ~i_out_ready;
    end

endmodule

// File: hw/rtl/wwa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind window averager controller
// Sequences the clearing pass, the ring update, the gust scan and the
// output load for one sample at a time.
// ----------------------------------------------------------------------------
module wwa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wwa_pkg::t_sts i_sts,
    output wwa_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_UPDATE = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write  = 1'b1;
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch_old = 1'b1;
                n_state         = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_read  = 1'b1;
                o_cmd.sweep_step = 1'b1;
                o_cmd.scan_start = i_sts.sweep_first;
                if (i_sts.sweep_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.div_done && !i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/wind_window_averager.sv
`timescale 1ns / 1ps
// Sequence: after a sample word is accepted, the controller steps through fetch, update, the gust
//   scan over every ring entry, drain and finish; the result word waits only while the previous one is held.
// Throughput: one sample at a time; a new sample word is taken only once the result word is loaded,
//   paced by the gust scan that reads one ring entry per cycle through a single memory port.
// Reset: synchronous, active low. A clearing pass over all WINDOW_LEN entries zeroes the rings;
//   input ready stays low until it ends. The offset register takes writes throughout.
// ----------------------------------------------------------------------------
// Wind window averager
// Moving-window mean speed, gust, corrected angle and mean angle of wind
// samples.
// ----------------------------------------------------------------------------
module wind_window_averager #(
    parameter int WINDOW_LEN = wwa_pkg::WINDOW_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wwa_pkg::ANGLE_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [wwa_pkg::ANGLE_W-1:0] i_raw_angle,
    input  logic [wwa_pkg::SPEED_W-1:0] i_wind_speed,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [wwa_pkg::SPEED_W-1:0] o_mean_speed,
    output logic [wwa_pkg::SPEED_W-1:0] o_gust_speed,
    output logic [wwa_pkg::ANGLE_W-1:0] o_true_angle,
    output logic [wwa_pkg::ANGLE_W-1:0] o_mean_angle
);

    wwa_pkg::t_cmd cmd;
    wwa_pkg::t_sts sts;

    // Sequencer.
    wwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Rings, totals and arithmetic.
    wwa_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_raw_angle  (i_raw_angle),
        .i_wind_speed (i_wind_speed),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_mean_speed (o_mean_speed),
        .o_gust_speed (o_gust_speed),
        .o_true_angle (o_true_angle),
        .o_mean_angle (o_mean_angle)
    );

endmodule

// File: hw/rtl/wwa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind window averager checker
// Port-level properties of the averager, bound to the top level.
// ----------------------------------------------------------------------------
module wwa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [wwa_pkg::ANGLE_W-1:0] i_cfg_wdata,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [wwa_pkg::ANGLE_W-1:0] i_raw_angle,
    input logic [wwa_pkg::SPEED_W-1:0] i_wind_speed,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [wwa_pkg::SPEED_W-1:0] o_mean_speed,
    input logic [wwa_pkg::SPEED_W-1:0] o_gust_speed,
    input logic [wwa_pkg::ANGLE_W-1:0] o_true_angle,
    input logic [wwa_pkg::ANGLE_W-1:0] o_mean_angle
);

    // Reset leaves no result pending and holds off input for the clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("output valid or input ready high right after reset");

    // Only one sample is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready high in the cycle after an accepted word");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mean_speed)
            && $stable(o_gust_speed) && $stable(o_true_angle) && $stable(o_mean_angle))
        else $error("result word changed while stalled");

    // The peak of the window is never below its mean.
    a_gust_ge_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_gust_speed >= o_mean_speed)
        else $error("gust speed below mean speed");

    // Corrected angle wraps below a full turn; the mean reaches a full turn at most.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_true_angle < wwa_pkg::ANGLE_FULL)
            && (o_mean_angle <= wwa_pkg::ANGLE_FULL))
        else $error("angle out of range");

endmodule

bind wind_window_averager wwa_checker u_wwa_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wind window averager testbench
// Feeds wind samples through the valid/ready input channel and checks each
// statistics word (mean speed, gust, corrected angle, mean angle) against a
// local model of the 120-entry window. The mounting offset is changed between
// phases while the block is idle. Both channels idle and stall at random, and
// the receiver holds off once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIN         = wwa_pkg::WINDOW_LEN_DEF;
    localparam int LONG_HOLD   = 2000;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        bit [wwa_pkg::ANGLE_W-1:0] raw_angle;
        bit [wwa_pkg::SPEED_W-1:0] wind_speed;
    } t_wind_sample;

    typedef struct {
        bit [wwa_pkg::SPEED_W-1:0] mean_speed;
        bit [wwa_pkg::SPEED_W-1:0] gust_speed;
        bit [wwa_pkg::ANGLE_W-1:0] true_angle;
        bit [wwa_pkg::ANGLE_W-1:0] mean_angle;
    } t_wind_stats;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_cfg_we     = 1'b0;
    logic [wwa_pkg::ANGLE_W-1:0] i_cfg_wdata  = '0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_ready;
    logic [wwa_pkg::ANGLE_W-1:0] i_raw_angle  = '0;
    logic [wwa_pkg::SPEED_W-1:0] i_wind_speed = '0;
    logic                        o_out_valid;
    logic                        i_out_ready  = 1'b0;
    logic [wwa_pkg::SPEED_W-1:0] o_mean_speed;
    logic [wwa_pkg::SPEED_W-1:0] o_gust_speed;
    logic [wwa_pkg::ANGLE_W-1:0] o_true_angle;
    logic [wwa_pkg::ANGLE_W-1:0] o_mean_angle;

    // Samples waiting to be offered and statistics words waiting to arrive.
    t_wind_sample sample_queue[$];
    t_wind_stats  expected_stats[$];

    // Local copy of the window state and the offset register.
    bit [wwa_pkg::SPEED_W-1:0] speed_window[WIN];
    bit [wwa_pkg::ANGLE_W-1:0] angle_window[WIN];
    int unsigned               head_slot    = 0;
    int unsigned               speed_sum    = 0;
    int unsigned               angle_sum    = 0;
    int unsigned               shifted_sum  = WIN * 1800;
    int unsigned               south_hits   = 0;
    bit [wwa_pkg::ANGLE_W-1:0] mount_offset = wwa_pkg::OFFSET_RESET;

    int  err_count     = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  recv_wait     = 0;
    bit  steady_send   = 1'b0;
    bit  steady_recv   = 1'b0;
    bit  hold_request  = 1'b0;
    int  fixed_offsets[4]   = '{3599, 1800, 0, 4095};
    int  boundary_angles[10] = '{0, 899, 900, 901, 1799, 1800, 2699, 2700, 2701, 3599};

    wind_window_averager uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_raw_angle  (i_raw_angle),
        .i_wind_speed (i_wind_speed),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_speed (o_mean_speed),
        .o_gust_speed (o_gust_speed),
        .o_true_angle (o_true_angle),
        .o_mean_angle (o_mean_angle)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // An angle shifted by half a turn, so that angles near north sum cleanly.
    function automatic int unsigned shift_half(input int unsigned a);
        return (a < wwa_pkg::ANGLE_HALF) ? a + wwa_pkg::ANGLE_HALF : a - wwa_pkg::ANGLE_HALF;
    endfunction

    function automatic bit in_south(input int unsigned a);
        return (a > wwa_pkg::SOUTH_LO) && (a <= wwa_pkg::SOUTH_HI);
    endfunction

    // Push one sample into the window and work out the statistics it yields.
    task automatic predict_wind_stats(input bit [wwa_pkg::ANGLE_W-1:0] raw,
                                      input bit [wwa_pkg::SPEED_W-1:0] spd);
        int unsigned ang;
        int unsigned old_a;
        int unsigned old_s;
        int unsigned gust;
        int          m;
        t_wind_stats r;
        ang = raw + mount_offset;
        while (ang >= wwa_pkg::ANGLE_FULL) ang -= wwa_pkg::ANGLE_FULL;
        old_a = angle_window[head_slot];
        old_s = speed_window[head_slot];
        speed_sum   = speed_sum - old_s + spd;
        angle_sum   = angle_sum - old_a + ang;
        shifted_sum = shifted_sum - shift_half(old_a) + shift_half(ang);
        if (in_south(old_a)) south_hits--;
        if (in_south(ang)) south_hits++;
        speed_window[head_slot] = spd;
        angle_window[head_slot] = ang;
        gust = 0;
        for (int i = 0; i < WIN; i++) begin
            if (speed_window[i] > gust) gust = speed_window[i];
        end
        // Mostly south: plain mean. Otherwise the shifted mean, folded back.
        if (south_hits > WIN / 2) begin
            r.mean_angle = angle_sum / WIN;
        end else begin
            m = int'(shifted_sum / WIN) - int'(wwa_pkg::ANGLE_HALF);
            if (m <= 0) m += wwa_pkg::ANGLE_FULL;
            r.mean_angle = m;
        end
        head_slot = (head_slot + 1 == WIN) ? 0 : head_slot + 1;
        r.mean_speed = speed_sum / WIN;
        r.gust_speed = gust;
        r.true_angle = ang;
        expected_stats.push_back(r);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Sender: offers queued samples, with a random gap after each accepted word.
    always @(posedge i_clk) begin
        t_wind_sample next_item;
        if (i_in_valid && o_in_ready) begin
            predict_wind_stats(i_raw_angle, i_wind_speed);
            send_gap = steady_send ? 0 : $urandom_range(0, 4);
        end
        if (i_in_valid && !o_in_ready) begin
            // Word still pending; hold it as it is.
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
            next_item = sample_queue.pop_front();
            i_in_valid   <= 1'b1;
            i_raw_angle  <= next_item.raw_angle;
            i_wind_speed <= next_item.wind_speed;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: checks each word, then stalls for a random number of cycles.
    always @(posedge i_clk) begin
        t_wind_stats want;
        if (o_out_valid && i_out_ready) begin
            if (expected_stats.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d",
                         $time, o_mean_speed, o_gust_speed, o_true_angle, o_mean_angle);
            end else begin
                want = expected_stats.pop_front();
                check_field("mean_speed", want.mean_speed, o_mean_speed);
                check_field("gust_speed", want.gust_speed, o_gust_speed);
                check_field("true_angle", want.true_angle, o_true_angle);
                check_field("mean_angle", want.mean_angle, o_mean_angle);
            end
            recv_wait = steady_recv ? 0 : $urandom_range(0, 4);
        end
        if (hold_request) begin
            hold_request = 1'b0;
            recv_wait = LONG_HOLD;
        end
        if (recv_wait > 0) begin
            recv_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Wait until every queued sample is taken and every word has arrived.
    task automatic drain();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || expected_stats.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_offset(input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wwa_pkg::ANGLE_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mount_offset = wwa_pkg::ANGLE_W'(value);
    endtask

    // Random samples in segments: clustered north or south, uniform, raw noise,
    // boundary angles, or one boundary angle held for the whole segment.
    task automatic queue_random_run(input int count);
        int left;
        int seg_len;
        int aim_mode;
        int pace_mode;
        int fixed_aim;
        int aim;
        int spd;
        int raw_val;
        left = count;
        while (left > 0) begin
            seg_len = $urandom_range(30, 180);
            if (seg_len > left) seg_len = left;
            aim_mode  = $urandom_range(0, 5);
            pace_mode = $urandom_range(0, 2);
            fixed_aim = boundary_angles[$urandom_range(0, 9)];
            for (int k = 0; k < seg_len; k++) begin
                case (aim_mode)
                    0: aim = ($urandom_range(0, 600) + 3300) % 3600;
                    1: aim = $urandom_range(900, 2700);
                    2: aim = $urandom_range(0, 3599);
                    4: aim = boundary_angles[$urandom_range(0, 9)];
                    default: aim = fixed_aim;
                endcase
                case (pace_mode)
                    0: spd = $urandom_range(0, 2047);
                    1: spd = ($urandom_range(0, 39) == 0) ? $urandom_range(1024, 2047)
                                                         : $urandom_range(0, 60);
                    default: spd = $urandom_range(0, 20);
                endcase
                if (aim_mode == 3) begin
                    raw_val = $urandom_range(0, 4095);
                end else begin
                    // Pick the raw angle that lands on the aimed true angle.
                    raw_val = (aim + 3600 - (mount_offset % 3600)) % 3600;
                    if ($urandom_range(0, 9) == 0 && raw_val + 3600 <= 4095)
                        raw_val += 3600;
                end
                sample_queue.push_back('{raw_angle: raw_val, wind_speed: spd});
            end
            left -= seg_len;
        end
    endtask

    // Test sequence.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset offset: field extremes and a sum that wraps to exactly zero.
        sample_queue.push_back('{raw_angle: 0,    wind_speed: 0});
        sample_queue.push_back('{raw_angle: 3599, wind_speed: 2047});
        sample_queue.push_back('{raw_angle: 4095, wind_speed: 1});
        sample_queue.push_back('{raw_angle: 2850, wind_speed: 1024});
        sample_queue.push_back('{raw_angle: 2849, wind_speed: 1023});
        sample_queue.push_back('{raw_angle: 0,    wind_speed: 0});
        drain();

        // Zero offset: the south band edges and the half-turn split.
        write_offset(0);
        sample_queue.push_back('{raw_angle: 900,  wind_speed: 5});
        sample_queue.push_back('{raw_angle: 901,  wind_speed: 2047});
        sample_queue.push_back('{raw_angle: 2700, wind_speed: 0});
        sample_queue.push_back('{raw_angle: 2701, wind_speed: 1365});
        sample_queue.push_back('{raw_angle: 1799, wind_speed: 682});
        sample_queue.push_back('{raw_angle: 1800, wind_speed: 3});
        sample_queue.push_back('{raw_angle: 3599, wind_speed: 7});
        sample_queue.push_back('{raw_angle: 4095, wind_speed: 2046});
        drain();

        // Largest offset: a sum that needs two wraps.
        write_offset(4095);
        sample_queue.push_back('{raw_angle: 4095, wind_speed: 11});
        sample_queue.push_back('{raw_angle: 0,    wind_speed: 2047});
        sample_queue.push_back('{raw_angle: 3105, wind_speed: 0});
        drain();

        // Random phases, each under its own offset.
        for (int p = 0; p < 8; p++) begin
            write_offset((p % 2 == 1) ? $urandom_range(0, 4095) : fixed_offsets[p / 2]);
            steady_send = (p == 3);
            steady_recv = (p == 3 || p == 6);
            queue_random_run(210);
            // Long receiver stall while the sender keeps offering.
            if (p == 1) hold_request = 1'b1;
            drain();
        end

        repeat (WIN + 10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
